// ===== hdl/snfcs_pkg.sv =====
// snfcs_pkg: shared types, opcodes and defaults for the spi nor command sequencer
// no dependencies; imported by snfcs_step, the top level and both testbench modules
`timescale 1ns / 1ps

package snfcs_pkg;

  // default geometry, handed to the top level parameters
  localparam int PAGE_BYTES_DEF   = 256;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int MAX_FRAMES_DEF   = 64;

  // fixed field widths
  localparam int ADDR_W = 24;
  localparam int LEN_W  = 14;
  localparam int CMD_W  = 3;

  // longest program or erase accepted
  localparam logic [LEN_W-1:0] LENGTH_LIMIT = 14'd16128;

  // host request codes; the unused code is rejected
  typedef enum logic [CMD_W-1:0] {
    CMD_READ        = 3'd0,
    CMD_PROGRAM     = 3'd1,
    CMD_ERASE_RANGE = 3'd2,
    CMD_ERASE_CHIP  = 3'd3,
    CMD_READ_ID     = 3'd4,
    CMD_POWER_DOWN  = 3'd5,
    CMD_STANDBY     = 3'd6
  } cmd_t;

  // flash instruction bytes
  localparam logic [7:0] OP_NONE       = 8'h00;
  localparam logic [7:0] OP_PROGRAM    = 8'h02;
  localparam logic [7:0] OP_READ       = 8'h03;
  localparam logic [7:0] OP_ERASE_4K   = 8'h20;
  localparam logic [7:0] OP_READ_ID    = 8'h90;
  localparam logic [7:0] OP_POWER_DOWN = 8'hB9;
  localparam logic [7:0] OP_STANDBY    = 8'hAB;
  localparam logic [7:0] OP_ERASE_ALL  = 8'hC7;

  // read id returns manufacturer and device bytes
  localparam logic [LEN_W-1:0] READ_ID_BYTES = 14'd2;

  // data phase direction
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_WRITE = 2'd1,
    DIR_READ  = 2'd2
  } dir_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_RUN   = 2'd2
  } state_t;

  // one frame descriptor
  typedef struct packed {
    logic [7:0]       opcode;
    logic [ADDR_W-1:0] address;
    logic             has_address;
    logic [LEN_W-1:0] data_count;
    dir_t             direction;
    logic             wen_first;
    logic             poll_before;
    logic             poll_after;
    logic             err;
    logic             is_last;
  } frame_t;

  // result of one pass through the step unit
  typedef struct packed {
    logic [LEN_W-1:0]  piece;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] next_addr;
    logic [LEN_W-1:0]  rem_left;
    logic              is_last;
  } step_t;

endpackage

// ===== hdl/snfcs_step.sv =====
// snfcs_step: shared boundary step unit, cuts one piece off a range at the next
// page or sector boundary; depends on snfcs_pkg
`timescale 1ns / 1ps

module snfcs_step
  import snfcs_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [LEN_W-1:0]  rem_i,
  input  logic              sector_i,
  output step_t             step_o
);

  localparam int PL   = $clog2(PAGE_BYTES);
  localparam int SL   = $clog2(SECTOR_BYTES);
  localparam int MAXL = (PL > SL) ? PL : SL;
  localparam int BW   = MAXL + 1;
  localparam int CW   = (BW > LEN_W) ? BW : LEN_W;

  logic [BW-1:0] blk;
  logic [BW-1:0] off;
  logic [BW-1:0] gap;
  logic          fits;
  logic [LEN_W-1:0] piece;

  // distance to the next boundary of the selected block size
  always_comb begin
    blk  = sector_i ? BW'(SECTOR_BYTES) : BW'(PAGE_BYTES);
    off  = sector_i ? BW'(addr_i[SL-1:0]) : BW'(addr_i[PL-1:0]);
    gap  = blk - off;
    fits = CW'(gap) >= CW'(rem_i);
    piece = fits ? rem_i : LEN_W'(gap);
  end

  // piece, sector base, advanced address and what is left
  always_comb begin
    step_o.piece     = piece;
    step_o.base      = addr_i & ~ADDR_W'(SECTOR_BYTES - 1);
    step_o.next_addr = addr_i + ADDR_W'(piece);
    step_o.rem_left  = rem_i - piece;
    step_o.is_last   = fits;
  end

endmodule

// ===== hdl/spi_nor_flash_command_sequencer.sv =====
// spi_nor_flash_command_sequencer: top level, request sequencer and descriptor register
// depends on snfcs_pkg and snfcs_step
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Busy rises in the next
// cycle. ST_CHECK checks the request; read, read id, chip erase, power down,
// standby, rejected and zero-length requests then give their single descriptor
// and the block is free again. Program and range erase then give one descriptor
// per cycle from ST_RUN, one per page piece or per sector touched, up to
// MAX_FRAMES descriptors; the one shared boundary step unit sets that pace. Each
// descriptor sits on the out_ ports for exactly one cycle with out_strobe high,
// in the cycle after it is formed; the receiver must take it then. PAGE_BYTES
// and SECTOR_BYTES must be powers of two.
module spi_nor_flash_command_sequencer
  import snfcs_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int MAX_FRAMES   = MAX_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ADDR_W-1:0] in_start_address,
  input  logic [LEN_W-1:0]  in_byte_length,
  output logic              out_strobe,
  output logic [7:0]        out_opcode,
  output logic [ADDR_W-1:0] out_frame_address,
  output logic              out_has_address,
  output logic [LEN_W-1:0]  out_data_count,
  output logic [1:0]        out_data_direction,
  output logic              out_write_enable_first,
  output logic              out_poll_before,
  output logic              out_poll_after,
  output logic              out_request_error,
  output logic              out_last_frame
);

  localparam int PL  = $clog2(PAGE_BYTES);
  localparam int SL  = $clog2(SECTOR_BYTES);
  localparam int EW  = ADDR_W + 1;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [EW-1:0]     end_r, end_nxt;
  logic              strobe_r, strobe_nxt;
  frame_t            frame_r, frame_nxt;

  logic              sector_sel;
  step_t             step;
  logic [EW-1:0]     first_blk;
  logic [EW-1:0]     last_blk;
  logic [EW-1:0]     span;
  logic              too_long;

  assign sector_sel = (cmd_r == CMD_ERASE_RANGE);

  // shared boundary step unit
  snfcs_step #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_step (
    .addr_i   (addr_r),
    .rem_i    (rem_r),
    .sector_i (sector_sel),
    .step_o   (step)
  );

  // block count check on the unwrapped end address
  always_comb begin
    first_blk = sector_sel ? ({1'b0, addr_r} >> SL) : ({1'b0, addr_r} >> PL);
    last_blk  = sector_sel ? (end_r >> SL) : (end_r >> PL);
    span      = last_blk - first_blk;
    too_long  = (rem_r > LENGTH_LIMIT) || (span >= EW'(MAX_FRAMES));
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // request and descriptor payload
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    addr_r  <= addr_nxt;
    rem_r   <= rem_nxt;
    end_r   <= end_nxt;
    frame_r <= frame_nxt;
  end

  // next state and descriptor forming
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    rem_nxt    = rem_r;
    end_nxt    = end_r;
    strobe_nxt = 1'b0;
    frame_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_t'(in_cmd);
          addr_nxt  = in_start_address;
          rem_nxt   = in_byte_length;
          end_nxt   = {1'b0, in_start_address} + EW'(in_byte_length) - EW'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        strobe_nxt        = 1'b1;
        state_nxt         = ST_IDLE;
        frame_nxt.is_last = 1'b1;
        case (cmd_r)
          CMD_READ: begin
            frame_nxt.opcode      = OP_READ;
            frame_nxt.address     = addr_r;
            frame_nxt.has_address = 1'b1;
            frame_nxt.data_count  = rem_r;
            frame_nxt.direction   = DIR_READ;
            frame_nxt.poll_before = 1'b1;
          end
          CMD_PROGRAM, CMD_ERASE_RANGE: begin
            if (rem_r == '0) begin
              frame_nxt.opcode = OP_NONE;
            end else if (too_long) begin
              frame_nxt.err = 1'b1;
            end else begin
              strobe_nxt = 1'b0;
              frame_nxt  = '0;
              state_nxt  = ST_RUN;
            end
          end
          CMD_ERASE_CHIP: begin
            frame_nxt.opcode      = OP_ERASE_ALL;
            frame_nxt.wen_first   = 1'b1;
            frame_nxt.poll_before = 1'b1;
            frame_nxt.poll_after  = 1'b1;
          end
          CMD_READ_ID: begin
            frame_nxt.opcode      = OP_READ_ID;
            frame_nxt.has_address = 1'b1;
            frame_nxt.data_count  = READ_ID_BYTES;
            frame_nxt.direction   = DIR_READ;
            frame_nxt.poll_before = 1'b1;
          end
          CMD_POWER_DOWN: begin
            frame_nxt.opcode = OP_POWER_DOWN;
          end
          CMD_STANDBY: begin
            frame_nxt.opcode     = OP_STANDBY;
            frame_nxt.poll_after = 1'b1;
          end
          default: begin
            frame_nxt.err = 1'b1;
          end
        endcase
      end
      ST_RUN: begin
        strobe_nxt            = 1'b1;
        frame_nxt.has_address = 1'b1;
        frame_nxt.wen_first   = 1'b1;
        frame_nxt.poll_before = 1'b1;
        frame_nxt.is_last     = step.is_last;
        if (sector_sel) begin
          frame_nxt.opcode  = OP_ERASE_4K;
          frame_nxt.address = step.base;
        end else begin
          frame_nxt.opcode     = OP_PROGRAM;
          frame_nxt.address    = addr_r;
          frame_nxt.data_count = step.piece;
          frame_nxt.direction  = DIR_WRITE;
        end
        addr_nxt = step.next_addr;
        rem_nxt  = step.rem_left;
        if (step.is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ports
  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = strobe_r;
  assign out_opcode             = frame_r.opcode;
  assign out_frame_address      = frame_r.address;
  assign out_has_address        = frame_r.has_address;
  assign out_data_count         = frame_r.data_count;
  assign out_data_direction     = frame_r.direction;
  assign out_write_enable_first = frame_r.wen_first;
  assign out_poll_before        = frame_r.poll_before;
  assign out_poll_after         = frame_r.poll_after;
  assign out_request_error      = frame_r.err;
  assign out_last_frame         = frame_r.is_last;

endmodule

// ===== hdl/snfcs_checker.sv =====
// snfcs_checker: port-level assertions for the command sequencer, bound to the top
// depends on spi_nor_flash_command_sequencer
`timescale 1ns / 1ps

module snfcs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_request_error,
  input logic out_last_frame
);

  // a taken request makes the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // descriptors of one request come back to back
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_frame |=> out_strobe)
    else $error("gap inside a descriptor run");

  // a descriptor that is not the last keeps the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_frame |-> busy)
    else $error("block free before the last descriptor");

  // nothing follows the last descriptor directly
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_frame |=> !out_strobe)
    else $error("descriptor after the last one");

  // an error descriptor ends its request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_request_error |-> out_last_frame)
    else $error("error descriptor not marked last");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_request_error (out_request_error),
  .out_last_frame    (out_last_frame)
);

// ===== tb/sv/descriptor_checker.sv =====
// descriptor_checker: watches the request and descriptor ports of the spi nor
// command sequencer, predicts every frame descriptor and compares it field by field
// depends on snfcs_pkg
`timescale 1ns / 1ps

module descriptor_checker
  import snfcs_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int MAX_FRAMES   = MAX_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [ADDR_W-1:0] in_start_address,
  input  logic [LEN_W-1:0]  in_byte_length,
  input  logic              out_strobe,
  input  logic [7:0]        out_opcode,
  input  logic [ADDR_W-1:0] out_frame_address,
  input  logic              out_has_address,
  input  logic [LEN_W-1:0]  out_data_count,
  input  logic [1:0]        out_data_direction,
  input  logic              out_write_enable_first,
  input  logic              out_poll_before,
  input  logic              out_poll_after,
  input  logic              out_request_error,
  input  logic              out_last_frame,
  input  logic              run_over,
  output int                mismatch_count,
  output int                frames_pending,
  output int                request_count,
  output int                frame_count
);

  // one expected frame descriptor
  typedef struct packed {
    logic [7:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic              has_address;
    logic [LEN_W-1:0]  data_count;
    dir_t              direction;
    logic              wen_first;
    logic              poll_before;
    logic              poll_after;
    logic              err;
    logic              is_last;
  } descr_t;

  descr_t frames_due[$];
  bit     leftovers_checked = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] descriptor mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("frame %0d %s got 0x%0h expected 0x%0h",
                                frame_count, name, got, want));
  endtask

  task automatic push_frame(input logic [7:0] op, input logic [ADDR_W-1:0] fa,
                            input logic ha, input logic [LEN_W-1:0] cnt,
                            input dir_t dir, input logic wen, input logic pb,
                            input logic pa, input logic err, input logic last);
    frames_due.push_back('{op, fa, ha, cnt, dir, wen, pb, pa, err, last});
  endtask

  // rejected and empty requests both give one bare descriptor
  task automatic push_bare(input logic err);
    push_frame(OP_NONE, '0, 1'b0, '0, DIR_NONE, 1'b0, 1'b0, 1'b0, err, 1'b1);
  endtask

  // expected descriptors of one accepted request
  task automatic plan_frames(input logic [CMD_W-1:0] cmd,
                             input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len);
    int unsigned       rem;
    int unsigned       piece;
    int unsigned       pieces;
    int unsigned       first_sec;
    int unsigned       last_sec;
    int unsigned       sectors;
    logic [ADDR_W-1:0] at;
    case (cmd)
      CMD_READ: begin
        push_frame(OP_READ, addr, 1'b1, len, DIR_READ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      end
      CMD_PROGRAM: begin
        pieces = (addr % PAGE_BYTES + len + PAGE_BYTES - 1) / PAGE_BYTES;
        if (len == 0) begin
          push_bare(1'b0);
        end else if (len > LENGTH_LIMIT || pieces > MAX_FRAMES) begin
          push_bare(1'b1);
        end else begin
          // split at page boundaries, address wraps at the top of flash
          at  = addr;
          rem = len;
          while (rem > 0) begin
            piece = PAGE_BYTES - (at % PAGE_BYTES);
            if (rem < piece) piece = rem;
            rem = rem - piece;
            push_frame(OP_PROGRAM, at, 1'b1, LEN_W'(piece), DIR_WRITE,
                       1'b1, 1'b1, 1'b0, 1'b0, rem == 0);
            at = at + ADDR_W'(piece);
          end
        end
      end
      CMD_ERASE_RANGE: begin
        // sector numbers come from the unwrapped end address
        first_sec = addr / SECTOR_BYTES;
        last_sec  = (32'(addr) + 32'(len) - 1) / SECTOR_BYTES;
        sectors   = last_sec - first_sec + 1;
        if (len == 0) begin
          push_bare(1'b0);
        end else if (len > LENGTH_LIMIT || sectors > MAX_FRAMES) begin
          push_bare(1'b1);
        end else begin
          for (int unsigned i = 0; i < sectors; i++)
            push_frame(OP_ERASE_4K, ADDR_W'((first_sec + i) * SECTOR_BYTES), 1'b1,
                       '0, DIR_NONE, 1'b1, 1'b1, 1'b0, 1'b0, i + 1 == sectors);
        end
      end
      CMD_ERASE_CHIP: begin
        push_frame(OP_ERASE_ALL, '0, 1'b0, '0, DIR_NONE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      end
      CMD_READ_ID: begin
        push_frame(OP_READ_ID, '0, 1'b1, READ_ID_BYTES, DIR_READ,
                   1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      end
      CMD_POWER_DOWN: begin
        push_frame(OP_POWER_DOWN, '0, 1'b0, '0, DIR_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
      CMD_STANDBY: begin
        push_frame(OP_STANDBY, '0, 1'b0, '0, DIR_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      end
      default: begin
        push_bare(1'b1);
      end
    endcase
  endtask

  // compare descriptors first, then record a new request taken at this edge
  always @(posedge clk) begin
    descr_t want;
    if (!rst_n) begin
      frames_due.delete();
    end else begin
      if (out_strobe === 1'b1) begin
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("descriptor with opcode 0x%0h and nothing expected",
                                    out_opcode));
        end else begin
          want = frames_due.pop_front();
          check_field("opcode", out_opcode, want.opcode);
          check_field("frame_address", out_frame_address, want.address);
          check_field("has_address", out_has_address, want.has_address);
          check_field("data_count", out_data_count, want.data_count);
          check_field("data_direction", out_data_direction, want.direction);
          check_field("write_enable_first", out_write_enable_first, want.wen_first);
          check_field("poll_before", out_poll_before, want.poll_before);
          check_field("poll_after", out_poll_after, want.poll_after);
          check_field("request_error", out_request_error, want.err);
          check_field("last_frame", out_last_frame, want.is_last);
        end
        frame_count++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        plan_frames(in_cmd, in_start_address, in_byte_length);
        request_count++;
      end
      if (run_over && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (frames_due.size() != 0)
          report_mismatch($sformatf("%0d descriptors never arrived", frames_due.size()));
      end
    end
    frames_pending = frames_due.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: directed and random flash requests into the spi nor command sequencer,
// with descriptor_checker beside it predicting and comparing every descriptor
// depends on snfcs_pkg, descriptor_checker and the sequencer rtl
`timescale 1ns / 1ps

module tb_top;
  import snfcs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 460;
  localparam int QUIET_TAIL      = 60;
  localparam int SETTLE_CYCLES   = MAX_FRAMES_DEF + 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd;
  logic [ADDR_W-1:0] in_start_address;
  logic [LEN_W-1:0]  in_byte_length;
  logic              out_strobe;
  logic [7:0]        out_opcode;
  logic [ADDR_W-1:0] out_frame_address;
  logic              out_has_address;
  logic [LEN_W-1:0]  out_data_count;
  logic [1:0]        out_data_direction;
  logic              out_write_enable_first;
  logic              out_poll_before;
  logic              out_poll_after;
  logic              out_request_error;
  logic              out_last_frame;
  logic              run_over;
  int                mismatch_count;
  int                frames_pending;
  int                request_count;
  int                frame_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  spi_nor_flash_command_sequencer i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_cmd                 (in_cmd),
    .in_start_address       (in_start_address),
    .in_byte_length         (in_byte_length),
    .out_strobe             (out_strobe),
    .out_opcode             (out_opcode),
    .out_frame_address      (out_frame_address),
    .out_has_address        (out_has_address),
    .out_data_count         (out_data_count),
    .out_data_direction     (out_data_direction),
    .out_write_enable_first (out_write_enable_first),
    .out_poll_before        (out_poll_before),
    .out_poll_after         (out_poll_after),
    .out_request_error      (out_request_error),
    .out_last_frame         (out_last_frame)
  );

  descriptor_checker i_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_cmd                 (in_cmd),
    .in_start_address       (in_start_address),
    .in_byte_length         (in_byte_length),
    .out_strobe             (out_strobe),
    .out_opcode             (out_opcode),
    .out_frame_address      (out_frame_address),
    .out_has_address        (out_has_address),
    .out_data_count         (out_data_count),
    .out_data_direction     (out_data_direction),
    .out_write_enable_first (out_write_enable_first),
    .out_poll_before        (out_poll_before),
    .out_poll_after         (out_poll_after),
    .out_request_error      (out_request_error),
    .out_last_frame         (out_last_frame),
    .run_over               (run_over),
    .mismatch_count         (mismatch_count),
    .frames_pending         (frames_pending),
    .request_count          (request_count),
    .frame_count            (frame_count)
  );

  // drive one request at a falling edge and hold it until the block takes it
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len, input bit idle_ok);
    @(negedge clk);
    if (idle_ok && $urandom_range(0, 2) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start            = 1'b1;
    in_cmd           = cmd;
    in_start_address = addr;
    in_byte_length   = len;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // addresses biased toward page ends, sector starts and the top of flash
  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 4))
      0: return ADDR_W'($urandom());
      1: return {16'($urandom()), 8'($urandom_range(8'hF0, 8'hFF))};
      2: return {12'hFFF, 12'($urandom())};
      3: return {12'($urandom()), 12'h000};
      default: return ADDR_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // lengths: often small, with zero, limit, over-limit and full-range values
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return LEN_W'($urandom_range(1, 300));
      4: return LEN_W'($urandom_range(1, 16) * 256);
      5: return LEN_W'($urandom_range(300, 4200));
      6: return LEN_W'($urandom_range(4200, 16128));
      7: return LENGTH_LIMIT - LEN_W'($urandom_range(0, 2));
      8: return LEN_W'($urandom_range(16129, 16383));
      default: return LEN_W'($urandom());
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    case ($urandom_range(0, 19))
      0, 1: return CMD_READ;
      2, 3, 4, 5, 6, 7, 8: return CMD_PROGRAM;
      9, 10, 11, 12, 13: return CMD_ERASE_RANGE;
      14: return CMD_ERASE_CHIP;
      15, 16: return CMD_READ_ID;
      17: return CMD_POWER_DOWN;
      18: return CMD_STANDBY;
      default: return CMD_UNUSED;
    endcase
  endfunction

  initial begin
    bit idle_ok;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_cmd           = '0;
    in_start_address = '0;
    in_byte_length   = '0;
    run_over         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed requests: field extremes, every command and the corner cases
    send_request(CMD_READ, 24'h000000, 14'd0, 1'b0);
    send_request(CMD_READ, 24'hFFFFFF, 14'h3FFF, 1'b0);
    send_request(CMD_PROGRAM, 24'h000000, 14'd0, 1'b0);
    send_request(CMD_PROGRAM, 24'h0000FF, 14'd1, 1'b0);
    send_request(CMD_PROGRAM, 24'h000100, 14'd256, 1'b0);
    send_request(CMD_PROGRAM, 24'hFFFFF0, 14'd64, 1'b0);
    send_request(CMD_PROGRAM, 24'h0000FF, LENGTH_LIMIT, 1'b0);
    send_request(CMD_PROGRAM, 24'hFFFFFF, LENGTH_LIMIT, 1'b0);
    send_request(CMD_PROGRAM, 24'h000000, LENGTH_LIMIT + 14'd1, 1'b0);
    send_request(CMD_PROGRAM, 24'h123456, 14'h3FFF, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'h000000, 14'd0, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'h001000, 14'd1, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'h000FFF, 14'd2, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'h000000, 14'd4097, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'h000FFF, LENGTH_LIMIT, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'hFFFFFF, LENGTH_LIMIT, 1'b0);
    send_request(CMD_ERASE_RANGE, 24'hFFF000, LENGTH_LIMIT + 14'd1, 1'b0);
    send_request(CMD_ERASE_CHIP, 24'hFFFFFF, 14'h3FFF, 1'b0);
    send_request(CMD_READ_ID, 24'hA5A5A5, 14'h2AAA, 1'b0);
    send_request(CMD_POWER_DOWN, 24'h5A5A5A, 14'h1555, 1'b0);
    send_request(CMD_STANDBY, 24'h000000, 14'd0, 1'b0);
    send_request(CMD_UNUSED, 24'h000000, 14'd0, 1'b0);
    send_request(CMD_UNUSED, 24'hFFFFFF, 14'h3FFF, 1'b0);

    // random requests, sender gaps in some stretches and none at the end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      idle_ok = (i < RANDOM_REQUESTS - QUIET_TAIL) && ((i / 40) % 3 != 2);
      send_request(pick_command(), pick_address(), pick_length(), idle_ok);
    end
    @(negedge clk);
    start = 1'b0;

    // drain the outstanding descriptors, then let the block settle
    for (int n = 0; n < 20000 && frames_pending != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    run_over = 1'b1;
    @(negedge clk);

    $display("%0d requests over all seven commands and the unused code, %0d descriptors checked",
             request_count, frame_count);
    $display("includes empty, over-limit, page-split, sector-crossing and address-wrap requests");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/snfcs_pkg.sv
hdl/snfcs_step.sv
hdl/spi_nor_flash_command_sequencer.sv
hdl/snfcs_checker.sv
tb/sv/descriptor_checker.sv
tb/sv/tb_top.sv
